// File: rtl/vna_pkg.sv
package vna_pkg;

  localparam int IDX_W  = 12;
  localparam int TYPE_W = 2;
  localparam int POS_W  = 16;
  localparam int NORM_W = 16;
  localparam int SUM_W  = 48;
  localparam int MAG_W  = 15;
  localparam int SQ_W   = 30;
  localparam int LEN_W  = 32;
  localparam int Q_W    = 15;

  localparam logic [TYPE_W-1:0] REQ_LOAD = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_TRI  = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_READ = 2'd2;

  localparam logic [Q_W-1:0] UNIT_Q = 15'd16384;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] q;
  } ds_res_t;

endpackage

// File: rtl/vna_if.sv
interface vna_req_if;
  logic                             valid;
  logic                             ready;
  logic [vna_pkg::TYPE_W-1:0]       req_type;
  logic [vna_pkg::IDX_W-1:0]        index_a;
  logic [vna_pkg::IDX_W-1:0]        index_b;
  logic [vna_pkg::IDX_W-1:0]        index_c;
  logic signed [vna_pkg::POS_W-1:0] pos_x;
  logic signed [vna_pkg::POS_W-1:0] pos_y;
  logic signed [vna_pkg::POS_W-1:0] pos_z;

  modport source (output valid, req_type, index_a, index_b, index_c, pos_x, pos_y, pos_z,
                  input ready);
  modport sink (input valid, req_type, index_a, index_b, index_c, pos_x, pos_y, pos_z,
                output ready);
endinterface

interface vna_res_if;
  logic                              valid;
  logic                              ready;
  logic [vna_pkg::IDX_W-1:0]         vertex_index;
  logic signed [vna_pkg::NORM_W-1:0] norm_x;
  logic signed [vna_pkg::NORM_W-1:0] norm_y;
  logic signed [vna_pkg::NORM_W-1:0] norm_z;
  logic                              is_zero;

  modport source (output valid, vertex_index, norm_x, norm_y, norm_z, is_zero, input ready);
  modport sink (input valid, vertex_index, norm_x, norm_y, norm_z, is_zero, output ready);
endinterface

// File: rtl/vna_mul.sv
module vna_mul #(
  parameter int W = 16
) (
  input  logic                  clk,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic signed [2*W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// File: rtl/vna_divsqrt.sv
module vna_divsqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [vna_pkg::SQ_W-1:0]     num,
  input  logic [vna_pkg::LEN_W-1:0]    den,
  output vna_pkg::ds_res_t             res
);

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_DIV  = 2'd1;
  localparam logic [1:0] P_SQRT = 2'd2;

  logic [1:0]  phase;
  logic [4:0]  cnt;
  logic [31:0] rem;
  logic [31:0] dv;
  logic [30:0] quo;
  logic [30:0] nbits;
  logic [31:0] rad;
  logic [17:0] srem;
  logic [15:0] root;

  logic [32:0] rs;
  logic        dge;
  logic [19:0] s2;
  logic [19:0] tr;
  logic        sge;
  logic [15:0] root_next;
  logic [16:0] rinc;

  always_comb begin
    rs        = {rem, nbits[30]};
    dge       = rs >= {1'b0, dv};
    s2        = {srem, rad[31:30]};
    tr        = {2'b00, root, 2'b01};
    sge       = s2 >= tr;
    root_next = {root[14:0], sge};
    rinc      = {1'b0, root_next} + 17'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= P_IDLE;
      res.done <= 1'b0;
    end else begin
      res.done <= 1'b0;
      case (phase)
        P_IDLE: begin
          if (start) begin
            rem   <= {3'b000, num[vna_pkg::SQ_W-1:1]};
            nbits <= {num[0], 30'b0};
            dv    <= den;
            cnt   <= '0;
            phase <= P_DIV;
          end
        end
        P_DIV: begin
          rem   <= dge ? 32'(rs - {1'b0, dv}) : rs[31:0];
          quo   <= {quo[29:0], dge};
          nbits <= {nbits[29:0], 1'b0};
          cnt   <= cnt + 5'd1;
          if (cnt == 5'd30) begin
            rad   <= {1'b0, quo[29:0], dge};
            srem  <= '0;
            root  <= '0;
            cnt   <= '0;
            phase <= P_SQRT;
          end
        end
        P_SQRT: begin
          srem <= sge ? 18'(s2 - tr) : 18'(s2);
          root <= root_next;
          rad  <= {rad[29:0], 2'b00};
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd15) begin
            res.q    <= rinc[15:1];
            res.done <= 1'b1;
            phase    <= P_IDLE;
          end
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/vertex_normal_accumulator.sv
// Keeps vertex positions and per-vertex normal sums in two single-port-write memories and
// serves one request at a time; ready is high only while the sequencer is idle. A triangle
// makes three position reads, six cross-product terms through the one shared multiplier,
// and three read-modify-writes of the sums. A read first makes s (0 to 33) one-bit shifts
// that bring the largest sum magnitude below 2^15; each component then passes a start state,
// the shared bit-serial divide (31 steps), square root (16 steps) and a result hand-back.
// A held result stalls the read in its output state. Out-of-range reads answer at once with
// a zero normal. Memories are not cleared: a vertex must be loaded before any triangle or
// read uses it.
module vertex_normal_accumulator #(
  parameter int VERTEX_DEPTH = 4096,
  parameter int COORD_WIDTH  = 16
) (
  input  logic clk,
  input  logic rst,
  vna_req_if.sink   req,
  vna_res_if.source res
);

  localparam int AW  = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
  localparam int EW  = COORD_WIDTH + 1;
  localparam int MW  = (EW > 16) ? EW : 16;
  localparam int PW  = 2 * MW;
  localparam int NW  = PW + 1;
  localparam int ADW = ((NW > vna_pkg::SUM_W) ? NW : vna_pkg::SUM_W) + 1;
  localparam int PSW = 3 * COORD_WIDTH;
  localparam int SW  = vna_pkg::SUM_W;
  localparam int SMW = 3 * SW;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_TRI_RD  = 4'd1;
  localparam logic [3:0] S_TRI_MUL = 4'd2;
  localparam logic [3:0] S_TRI_ACC = 4'd3;
  localparam logic [3:0] S_RD_SUM  = 4'd4;
  localparam logic [3:0] S_SHIFT   = 4'd5;
  localparam logic [3:0] S_SQ      = 4'd6;
  localparam logic [3:0] S_DSTART  = 4'd7;
  localparam logic [3:0] S_DWAIT   = 4'd8;
  localparam logic [3:0] S_OUT     = 4'd9;

  logic [3:0] state;
  logic [2:0] cnt;
  logic [1:0] comp;
  logic [AW-1:0] idx_a, idx_b, idx_c;
  logic [vna_pkg::IDX_W-1:0] vidx;
  logic zero;

  logic signed [COORD_WIDTH-1:0] pv [3][3];
  logic signed [NW-1:0]          nsum [3];
  logic [SW-1:0]                 mag [3];
  logic                          neg [3];
  logic [vna_pkg::SQ_W-1:0]      sq [3];
  logic [vna_pkg::LEN_W-1:0]     len;
  logic [vna_pkg::Q_W-1:0]       qv [3];

  logic [PSW-1:0] pos_mem [VERTEX_DEPTH];
  logic [SMW-1:0] sum_mem [VERTEX_DEPTH];
  logic [PSW-1:0] pos_q;
  logic [SMW-1:0] sum_q;

  logic          accept;
  logic          a_ok, b_ok, c_ok;
  logic          pos_we;
  logic [PSW-1:0] pos_wdata;
  logic [AW-1:0] pos_raddr;
  logic          sum_we;
  logic [AW-1:0] sum_waddr;
  logic [SMW-1:0] sum_wdata;
  logic [AW-1:0] sum_raddr;
  logic [AW-1:0] acc_idx;
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;
  logic signed [ADW-1:0] wide [3];
  logic [SMW-1:0] acc_wdata;
  logic [2:0] pc;
  logic [SW-1:0] smag [3];
  logic          sneg [3];
  logic          any_hi;
  logic          ds_start;
  vna_pkg::ds_res_t ds_res;
  logic signed [vna_pkg::NORM_W-1:0] nout [3];
  logic          out_free;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign a_ok      = {20'b0, req.index_a} < 32'(VERTEX_DEPTH);
  assign b_ok      = {20'b0, req.index_b} < 32'(VERTEX_DEPTH);
  assign c_ok      = {20'b0, req.index_c} < 32'(VERTEX_DEPTH);
  assign pc        = cnt - 3'd1;
  assign out_free  = !res.valid || res.ready;
  assign ds_start  = (state == S_DSTART);

  always_comb begin
    case (cnt[2:1])
      2'd0:    acc_idx = idx_a;
      2'd1:    acc_idx = idx_b;
      default: acc_idx = idx_c;
    endcase
    case (cnt)
      3'd0:    pos_raddr = idx_a;
      3'd1:    pos_raddr = idx_b;
      default: pos_raddr = idx_c;
    endcase
  end

  always_comb begin
    pos_we    = accept && req.req_type == vna_pkg::REQ_LOAD && a_ok;
    pos_wdata = {COORD_WIDTH'(req.pos_z), COORD_WIDTH'(req.pos_y), COORD_WIDTH'(req.pos_x)};
    sum_raddr = (state == S_IDLE) ? AW'(req.index_a) : acc_idx;
    if (state == S_TRI_ACC) begin
      sum_we    = cnt[0];
      sum_waddr = acc_idx;
      sum_wdata = acc_wdata;
    end else begin
      sum_we    = pos_we;
      sum_waddr = AW'(req.index_a);
      sum_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[AW'(req.index_a)] <= pos_wdata;
    end
    pos_q <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sum_waddr] <= sum_wdata;
    end
    sum_q <= sum_mem[sum_raddr];
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e1[k]   = EW'(pv[0][k]) - EW'(pv[1][k]);
      e2[k]   = EW'(pv[2][k]) - EW'(pv[1][k]);
      wide[k] = ADW'($signed(sum_q[k*SW +: SW])) + ADW'(nsum[k]);
      if (wide[k] > ADW'(vna_pkg::SUM_MAX)) begin
        acc_wdata[k*SW +: SW] = vna_pkg::SUM_MAX;
      end else if (wide[k] < ADW'(vna_pkg::SUM_MIN)) begin
        acc_wdata[k*SW +: SW] = vna_pkg::SUM_MIN;
      end else begin
        acc_wdata[k*SW +: SW] = wide[k][SW-1:0];
      end
      sneg[k] = sum_q[k*SW + SW - 1];
      smag[k] = sneg[k] ? SW'(-sum_q[k*SW +: SW]) : sum_q[k*SW +: SW];
      nout[k] = neg[k] ? -$signed({1'b0, qv[k]}) : $signed({1'b0, qv[k]});
    end
    any_hi = (|mag[0][SW-1:vna_pkg::MAG_W]) || (|mag[1][SW-1:vna_pkg::MAG_W]) ||
             (|mag[2][SW-1:vna_pkg::MAG_W]);
  end

  always_comb begin
    if (state == S_SQ) begin
      case (cnt)
        3'd0:    mul_a = MW'($signed({1'b0, mag[0][vna_pkg::MAG_W-1:0]}));
        3'd1:    mul_a = MW'($signed({1'b0, mag[1][vna_pkg::MAG_W-1:0]}));
        default: mul_a = MW'($signed({1'b0, mag[2][vna_pkg::MAG_W-1:0]}));
      endcase
      mul_b = mul_a;
    end else begin
      case (cnt)
        3'd0:    begin mul_a = MW'(e2[1]); mul_b = MW'(e1[2]); end
        3'd1:    begin mul_a = MW'(e2[2]); mul_b = MW'(e1[1]); end
        3'd2:    begin mul_a = MW'(e2[2]); mul_b = MW'(e1[0]); end
        3'd3:    begin mul_a = MW'(e2[0]); mul_b = MW'(e1[2]); end
        3'd4:    begin mul_a = MW'(e2[0]); mul_b = MW'(e1[1]); end
        default: begin mul_a = MW'(e2[1]); mul_b = MW'(e1[0]); end
      endcase
    end
  end

  vna_mul #(.W(MW)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  vna_divsqrt u_ds (
    .clk   (clk),
    .rst   (rst),
    .start (ds_start),
    .num   (sq[comp]),
    .den   (len),
    .res   (ds_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res.valid <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            idx_a <= AW'(req.index_a);
            idx_b <= AW'(req.index_b);
            idx_c <= AW'(req.index_c);
            vidx  <= req.index_a;
            cnt   <= '0;
            case (req.req_type)
              vna_pkg::REQ_TRI: begin
                if (a_ok && b_ok && c_ok) begin
                  state <= S_TRI_RD;
                end
              end
              vna_pkg::REQ_READ: begin
                zero  <= !a_ok;
                state <= a_ok ? S_RD_SUM : S_OUT;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_TRI_RD: begin
          if (cnt != 3'd0) begin
            for (int k = 0; k < 3; k++) begin
              pv[pc[1:0]][k] <= $signed(pos_q[k*COORD_WIDTH +: COORD_WIDTH]);
            end
          end
          cnt <= cnt + 3'd1;
          if (cnt == 3'd3) begin
            cnt  <= '0;
            for (int k = 0; k < 3; k++) begin
              nsum[k] <= '0;
            end
            state <= S_TRI_MUL;
          end
        end
        S_TRI_MUL: begin
          if (cnt != 3'd0) begin
            nsum[pc[2:1]] <= pc[0] ? nsum[pc[2:1]] - NW'(mul_p)
                                   : nsum[pc[2:1]] + NW'(mul_p);
          end
          cnt <= cnt + 3'd1;
          if (cnt == 3'd6) begin
            cnt   <= '0;
            state <= S_TRI_ACC;
          end
        end
        S_TRI_ACC: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd5) begin
            state <= S_IDLE;
          end
        end
        S_RD_SUM: begin
          for (int k = 0; k < 3; k++) begin
            mag[k] <= smag[k];
            neg[k] <= sneg[k];
          end
          if (smag[0] == '0 && smag[1] == '0 && smag[2] == '0) begin
            zero  <= 1'b1;
            state <= S_OUT;
          end else begin
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (any_hi) begin
            for (int k = 0; k < 3; k++) begin
              mag[k] <= mag[k] >> 1;
            end
          end else begin
            cnt   <= '0;
            len   <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (cnt != 3'd0) begin
            sq[pc[1:0]] <= mul_p[vna_pkg::SQ_W-1:0];
            len         <= len + vna_pkg::LEN_W'(mul_p[vna_pkg::SQ_W-1:0]);
          end
          cnt <= cnt + 3'd1;
          if (cnt == 3'd3) begin
            comp  <= '0;
            state <= S_DSTART;
          end
        end
        S_DSTART: state <= S_DWAIT;
        S_DWAIT: begin
          if (ds_res.done) begin
            qv[comp] <= ds_res.q;
            if (comp == 2'd2) begin
              state <= S_OUT;
            end else begin
              comp  <= comp + 2'd1;
              state <= S_DSTART;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            res.valid        <= 1'b1;
            res.vertex_index <= vidx;
            res.is_zero      <= zero;
            res.norm_x       <= zero ? '0 : nout[0];
            res.norm_y       <= zero ? '0 : nout[1];
            res.norm_z       <= zero ? '0 : nout[2];
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_shift_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT |-> (mag[0] != '0 || mag[1] != '0 || mag[2] != '0))
    else $error("shift search entered with an all-zero sum");

  a_ds_done_wait: assert property (@(posedge clk) disable iff (rst)
    ds_res.done |-> state == S_DWAIT)
    else $error("divide/root result arrived outside its wait state");

  a_ds_unit: assert property (@(posedge clk) disable iff (rst)
    ds_res.done |-> ds_res.q <= vna_pkg::UNIT_Q)
    else $error("normal component above unit length");

  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.is_zero |-> res.norm_x == '0 && res.norm_y == '0 && res.norm_z == '0)
    else $error("zero-length result carries a nonzero normal");
`endif

endmodule

// File: tb/vertex_normal_accumulator_tb.sv
`timescale 1ns / 100ps

module vertex_normal_accumulator_tb;

  localparam int DEPTH     = 4096;
  localparam int CYCLE_CAP = 2000000;

  localparam logic [vna_pkg::TYPE_W-1:0] REQ_NOP = 2'd3;

  typedef struct {
    logic [vna_pkg::TYPE_W-1:0]       kind;
    logic [vna_pkg::IDX_W-1:0]        ia;
    logic [vna_pkg::IDX_W-1:0]        ib;
    logic [vna_pkg::IDX_W-1:0]        ic;
    logic signed [vna_pkg::POS_W-1:0] px;
    logic signed [vna_pkg::POS_W-1:0] py;
    logic signed [vna_pkg::POS_W-1:0] pz;
  } request_t;

  typedef struct {
    logic [vna_pkg::IDX_W-1:0]         vidx;
    logic signed [vna_pkg::NORM_W-1:0] nx;
    logic signed [vna_pkg::NORM_W-1:0] ny;
    logic signed [vna_pkg::NORM_W-1:0] nz;
    logic                              zero;
  } normal_t;

  typedef struct {
    request_t rq;
    bit       has_fixed;
    normal_t  fixed;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  vna_req_if req ();
  vna_res_if res ();

  vertex_normal_accumulator DUT (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .res(res.source)
  );

  logic signed [vna_pkg::POS_W-1:0] pos_tab [DEPTH][3];
  logic signed [vna_pkg::SUM_W-1:0] acc_tab [DEPTH][3];
  bit                               loaded [DEPTH];
  normal_t                          normals_due [$];
  int                               mismatches;
  int                               cycles;
  logic [vna_pkg::IDX_W-1:0]        live [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic logic signed [vna_pkg::SUM_W-1:0] sat_sum(
      input logic signed [vna_pkg::SUM_W-1:0] s, input longint d);
    longint r;
    r = longint'(s) + d;
    if (r > longint'(vna_pkg::SUM_MAX)) return vna_pkg::SUM_MAX;
    if (r < longint'(vna_pkg::SUM_MIN)) return vna_pkg::SUM_MIN;
    return r[vna_pkg::SUM_W-1:0];
  endfunction

  function automatic longint unsigned unit_part(input longint unsigned m,
                                                input longint unsigned len2);
    longint unsigned lo, hi, mid, t, rhs;
    lo = 0;
    hi = 16384;
    rhs = (m * m) << 30;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t = 2 * mid - 1;
      if (t * t * len2 <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic bit accumulate(input request_t r, output normal_t o);
    longint e1 [3];
    longint e2 [3];
    longint n [3];
    longint s [3];
    longint unsigned m [3];
    longint unsigned mx, len2, q;
    int sh;
    int idx [3];
    o.vidx = r.ia;
    o.nx = '0;
    o.ny = '0;
    o.nz = '0;
    o.zero = 1'b1;
    case (r.kind)
      vna_pkg::REQ_LOAD: begin
        pos_tab[r.ia][0] = r.px;
        pos_tab[r.ia][1] = r.py;
        pos_tab[r.ia][2] = r.pz;
        for (int k = 0; k < 3; k++) acc_tab[r.ia][k] = '0;
        loaded[r.ia] = 1'b1;
        return 0;
      end
      vna_pkg::REQ_TRI: begin
        for (int k = 0; k < 3; k++) begin
          e1[k] = longint'(pos_tab[r.ia][k]) - longint'(pos_tab[r.ib][k]);
          e2[k] = longint'(pos_tab[r.ic][k]) - longint'(pos_tab[r.ib][k]);
        end
        n[0] = e2[1] * e1[2] - e2[2] * e1[1];
        n[1] = e2[2] * e1[0] - e2[0] * e1[2];
        n[2] = e2[0] * e1[1] - e2[1] * e1[0];
        idx[0] = int'(r.ia);
        idx[1] = int'(r.ib);
        idx[2] = int'(r.ic);
        for (int j = 0; j < 3; j++)
          for (int k = 0; k < 3; k++) acc_tab[idx[j]][k] = sat_sum(acc_tab[idx[j]][k], n[k]);
        return 0;
      end
      vna_pkg::REQ_READ: begin
        mx = 0;
        for (int k = 0; k < 3; k++) begin
          s[k] = longint'(acc_tab[r.ia][k]);
          m[k] = s[k] < 0 ? longint'(-s[k]) : longint'(s[k]);
          if (m[k] > mx) mx = m[k];
        end
        if (mx == 0) return 1;
        sh = 0;
        while ((mx >> sh) >= 32768) sh++;
        len2 = 0;
        for (int k = 0; k < 3; k++) begin
          m[k] = m[k] >> sh;
          len2 += m[k] * m[k];
        end
        for (int k = 0; k < 3; k++) begin
          q = unit_part(m[k], len2);
          if (s[k] < 0) q = -q;
          if (k == 0) o.nx = q[vna_pkg::NORM_W-1:0];
          if (k == 1) o.ny = q[vna_pkg::NORM_W-1:0];
          if (k == 2) o.nz = q[vna_pkg::NORM_W-1:0];
        end
        o.zero = 1'b0;
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  task automatic send(input request_t r, input bit has_fixed, input normal_t fixed);
    normal_t o;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid    <= 1'b1;
    req.req_type <= r.kind;
    req.index_a  <= r.ia;
    req.index_b  <= r.ib;
    req.index_c  <= r.ic;
    req.pos_x    <= r.px;
    req.pos_y    <= r.py;
    req.pos_z    <= r.pz;
    do @(posedge clk); while (!req.ready);
    if (accumulate(r, o)) normals_due.push_back(has_fixed ? fixed : o);
  endtask

  function automatic request_t mk(input logic [vna_pkg::TYPE_W-1:0] kind, input int a,
                                  input int b, input int c, input int x, input int y,
                                  input int z);
    request_t r;
    r.kind = kind;
    r.ia = a[vna_pkg::IDX_W-1:0];
    r.ib = b[vna_pkg::IDX_W-1:0];
    r.ic = c[vna_pkg::IDX_W-1:0];
    r.px = x[vna_pkg::POS_W-1:0];
    r.py = y[vna_pkg::POS_W-1:0];
    r.pz = z[vna_pkg::POS_W-1:0];
    return r;
  endfunction

  function automatic logic [vna_pkg::IDX_W-1:0] pick_live();
    return live[$urandom_range(0, live.size() - 1)];
  endfunction

  function automatic request_t rand_req();
    request_t r;
    int sel;
    int v;
    sel = $urandom_range(0, 99);
    r = mk(vna_pkg::REQ_LOAD, pick_live(), pick_live(), pick_live(), $urandom, $urandom,
           $urandom);
    if (sel < 20) begin
      if ($urandom_range(0, 3) == 0) begin
        v = $urandom_range(0, DEPTH - 1);
        r.ia = v[vna_pkg::IDX_W-1:0];
      end
      if ($urandom_range(0, 2) == 0) begin
        r.px = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        r.pz = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      end
    end else if (sel < 65) begin
      r.kind = vna_pkg::REQ_TRI;
    end else if (sel < 95) begin
      r.kind = vna_pkg::REQ_READ;
      if ($urandom_range(0, 15) == 0) begin
        v = DEPTH - 1 - $urandom_range(0, 3);
        if (loaded[v]) r.ia = v[vna_pkg::IDX_W-1:0];
      end
    end else begin
      r.kind = REQ_NOP;
      v = $urandom_range(0, DEPTH - 1);
      r.ia = v[vna_pkg::IDX_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    normal_t got, want;
    if (!rst && res.valid && res.ready) begin
      got.vidx = res.vertex_index;
      got.nx = res.norm_x;
      got.ny = res.norm_y;
      got.nz = res.norm_z;
      got.zero = res.is_zero;
      if (normals_due.size() == 0) begin
        report($sformatf("unexpected normal for vertex %0d", got.vidx));
      end else begin
        want = normals_due.pop_front();
        if (got.vidx != want.vidx)
          report($sformatf("vertex_index %0d want %0d", got.vidx, want.vidx));
        if (got.nx != want.nx) report($sformatf("norm_x %0d want %0d", got.nx, want.nx));
        if (got.ny != want.ny) report($sformatf("norm_y %0d want %0d", got.ny, want.ny));
        if (got.nz != want.nz) report($sformatf("norm_z %0d want %0d", got.nz, want.nz));
        if (got.zero != want.zero)
          report($sformatf("is_zero %0b want %0b", got.zero, want.zero));
      end
    end
  end

  initial begin
    int hold;
    res.ready <= 1'b0;
    @(negedge rst);
    forever begin
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (hold != 0) begin
        res.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      res.ready <= 1'b1;
      do @(posedge clk); while (!res.valid);
    end
  end

  initial begin
    row_t    rows [$];
    row_t    w;
    normal_t zn;
    normal_t none;
    int      settle;
    int      v;
    mismatches = 0;
    cycles = 0;
    rst = 1'b1;
    req.valid    <= 1'b0;
    req.req_type <= vna_pkg::REQ_LOAD;
    req.index_a  <= '0;
    req.index_b  <= '0;
    req.index_c  <= '0;
    req.pos_x    <= '0;
    req.pos_y    <= '0;
    req.pos_z    <= '0;
    none = '{default: '0};
    zn = '{vidx: '0, nx: '0, ny: '0, nz: '0, zero: 1'b1};
    for (int i = 0; i < DEPTH; i++) loaded[i] = 1'b0;

    w.has_fixed = 1'b0;
    w.fixed = none;
    w.rq = mk(vna_pkg::REQ_LOAD, 0, 0, 0, 0, 0, 0);               rows.push_back(w);
    w.rq = mk(vna_pkg::REQ_LOAD, 1, 0, 0, 256, 0, 0);             rows.push_back(w);
    w.rq = mk(vna_pkg::REQ_LOAD, 2, 0, 0, 0, 256, 0);             rows.push_back(w);
    w.rq = mk(vna_pkg::REQ_LOAD, 4095, 0, 0, 0, 0, 256);          rows.push_back(w);
    w.rq = mk(vna_pkg::REQ_LOAD, 5, 0, 0, 32767, 32767, 32767);   rows.push_back(w);
    w.rq = mk(vna_pkg::REQ_LOAD, 6, 0, 0, -32768, -32768, 32767); rows.push_back(w);
    w.rq = mk(vna_pkg::REQ_LOAD, 7, 0, 0, 32767, -32768, -32768); rows.push_back(w);
    w.has_fixed = 1'b1;
    zn.vidx = 0;    w.fixed = zn; w.rq = mk(vna_pkg::REQ_READ, 0, 0, 0, 0, 0, 0);
    rows.push_back(w);
    zn.vidx = 4095; w.fixed = zn; w.rq = mk(vna_pkg::REQ_READ, 4095, 0, 0, 0, 0, 0);
    rows.push_back(w);
    w.has_fixed = 1'b0;
    w.rq = mk(vna_pkg::REQ_TRI, 1, 0, 2, 0, 0, 0);                rows.push_back(w);
    w.has_fixed = 1'b1;
    w.fixed = '{vidx: 12'd0, nx: 16'sd0, ny: 16'sd0, nz: -16'sd16384, zero: 1'b0};
    w.rq = mk(vna_pkg::REQ_READ, 0, 0, 0, 0, 0, 0);               rows.push_back(w);
    w.has_fixed = 1'b0;
    w.rq = mk(vna_pkg::REQ_TRI, 2, 0, 1, 0, 0, 0);                rows.push_back(w);
    w.has_fixed = 1'b1;
    zn.vidx = 0; w.fixed = zn; w.rq = mk(vna_pkg::REQ_READ, 0, 0, 0, 0, 0, 0);
    rows.push_back(w);
    w.has_fixed = 1'b0;
    w.rq = mk(vna_pkg::REQ_TRI, 5, 6, 7, 0, 0, 0);                rows.push_back(w);
    for (int i = 0; i < 6; i++) begin
      w.rq = mk(vna_pkg::REQ_TRI, 5, 6, 7, 0, 0, 0);              rows.push_back(w);
    end
    w.rq = mk(vna_pkg::REQ_READ, 6, 0, 0, 0, 0, 0);               rows.push_back(w);
    w.rq = mk(vna_pkg::REQ_TRI, 4095, 1, 2, 0, 0, 0);             rows.push_back(w);
    w.rq = mk(vna_pkg::REQ_READ, 4095, 0, 0, 0, 0, 0);            rows.push_back(w);
    w.rq = mk(REQ_NOP, 4095, 4095, 4095, -1, -1, -1);             rows.push_back(w);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send(rows[i].rq, rows[i].has_fixed, rows[i].fixed);

    for (int i = 0; i < 24; i++) begin
      v = $urandom_range(0, DEPTH - 1);
      live.push_back(v[vna_pkg::IDX_W-1:0]);
    end
    v = 0;
    live.push_back(v[vna_pkg::IDX_W-1:0]);
    v = DEPTH - 1;
    live.push_back(v[vna_pkg::IDX_W-1:0]);
    foreach (live[i])
      if (!loaded[live[i]])
        send(mk(vna_pkg::REQ_LOAD, live[i], 0, 0, $urandom, $urandom, $urandom), 1'b0, none);
    for (int i = 0; i < 400; i++) send(rand_req(), 1'b0, none);
    req.valid <= 1'b0;

    while (normals_due.size() != 0) @(posedge clk);
    settle = 0;
    while (settle < 300) begin
      @(posedge clk);
      settle++;
    end
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
